// ===== rtl/tit_pkg.sv =====
// trickle interval timer: shared types, constants and the microcode rom
// no dependencies; imported by tit_datapath and trickle_interval_timer_top
package tit_pkg;

    localparam int unsigned IntervalWidth = 16;
    localparam int unsigned FireWidth     = 17;
    localparam int unsigned PcWidth       = 3;
    localparam int unsigned AddrWidth     = 3;
    localparam int unsigned DataWidth     = 32;

    localparam logic [IntervalWidth-1:0] INITIAL_RESET = 16'd16;
    localparam logic [IntervalWidth-1:0] MAXIMUM_RESET = 16'd1024;

    // register indexes
    localparam logic REG_INITIAL = 1'b0;
    localparam logic REG_MAXIMUM = 1'b1;

    // operation codes of an input item
    localparam logic OP_RUN   = 1'b0;
    localparam logic OP_RESET = 1'b1;

    // program addresses
    localparam logic [PcWidth-1:0] PC_IDLE  = 3'd0;
    localparam logic [PcWidth-1:0] PC_GROW  = 3'd1;
    localparam logic [PcWidth-1:0] PC_HALF  = 3'd2;
    localparam logic [PcWidth-1:0] PC_DIV   = 3'd3;
    localparam logic [PcWidth-1:0] PC_TEMP  = 3'd4;
    localparam logic [PcWidth-1:0] PC_EMIT  = 3'd5;
    localparam logic [PcWidth-1:0] PC_CLEAR = 3'd6;

    // last division step count (16 quotient bits)
    localparam logic [3:0] DIV_LAST = 4'd15;

    typedef struct packed {
        logic                     operation;
        logic [IntervalWidth-1:0] random_value;
    } in_item_t;

    typedef struct packed {
        logic [FireWidth-1:0]     fire_time;
        logic [IntervalWidth-1:0] current_interval;
        logic                     at_initial;
    } out_item_t;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_LATCH,
        UOP_GROW,
        UOP_HALF,
        UOP_DIV,
        UOP_TEMP,
        UOP_CLEAR,
        UOP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_IF_RESET,
        JMP_IF_HALF_ZERO,
        JMP_IF_DIV_MORE
    } jump_t;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_OUT
    } hold_t;

    typedef struct packed {
        uop_t               uop;
        hold_t              hold;
        jump_t              jump;
        logic [PcWidth-1:0] target;
    } ucode_t;

    // control from sequencer to datapath
    typedef struct packed {
        uop_t                     uop;
        logic                     cfg_load;
        logic [IntervalWidth-1:0] initial_value;
        logic [IntervalWidth-1:0] maximum_value;
    } dp_ctrl_t;

    // status from datapath to sequencer
    typedef struct packed {
        logic op_reset;
        logic half_zero;
        logic div_more;
    } dp_stat_t;

    function automatic ucode_t ucode_rom(input logic [PcWidth-1:0] pc);
        ucode_t w;
        unique case (pc)
            PC_IDLE:  w = '{uop: UOP_LATCH, hold: HOLD_IN,   jump: JMP_IF_RESET,
                            target: PC_CLEAR};
            PC_GROW:  w = '{uop: UOP_GROW,  hold: HOLD_NONE, jump: JMP_NEXT,
                            target: PC_IDLE};
            PC_HALF:  w = '{uop: UOP_HALF,  hold: HOLD_NONE, jump: JMP_IF_HALF_ZERO,
                            target: PC_TEMP};
            PC_DIV:   w = '{uop: UOP_DIV,   hold: HOLD_NONE, jump: JMP_IF_DIV_MORE,
                            target: PC_DIV};
            PC_TEMP:  w = '{uop: UOP_TEMP,  hold: HOLD_NONE, jump: JMP_NEXT,
                            target: PC_IDLE};
            PC_EMIT:  w = '{uop: UOP_EMIT,  hold: HOLD_OUT,  jump: JMP_ALWAYS,
                            target: PC_IDLE};
            PC_CLEAR: w = '{uop: UOP_CLEAR, hold: HOLD_NONE, jump: JMP_ALWAYS,
                            target: PC_EMIT};
            default:  w = '{uop: UOP_NOP,   hold: HOLD_NONE, jump: JMP_ALWAYS,
                            target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/tit_datapath.sv =====
// trickle interval timer datapath: interval state, restoring divider
// depends on tit_pkg; driven one micro-op per cycle by the top-level sequencer, a nop while a step waits
module tit_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tit_pkg::dp_ctrl_t                ctrl,
    input  tit_pkg::in_item_t                in_item,
    output tit_pkg::dp_stat_t                stat,
    output logic [tit_pkg::FireWidth-1:0]     fire_time,
    output logic [tit_pkg::IntervalWidth-1:0] interval
);
    import tit_pkg::*;

    logic [IntervalWidth-1:0] interval_reg, interval_next;
    logic                     scale_reg, scale_next;
    logic [IntervalWidth-1:0] leftover_reg, leftover_next;
    logic                     op_reg, op_next;
    logic [IntervalWidth-1:0] rnd_reg, rnd_next;
    logic [IntervalWidth-2:0] half_reg, half_next;
    logic [IntervalWidth-2:0] rem_reg, rem_next;
    logic [3:0]               cnt_reg, cnt_next;
    logic [FireWidth-1:0]     fire_reg, fire_next;

    logic [IntervalWidth-1:0] rem_shift;
    logic [IntervalWidth-1:0] rem_sub;
    logic [IntervalWidth-1:0] temp;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, rnd_reg[IntervalWidth-1]};
    assign rem_sub   = rem_shift - {1'b0, half_reg};
    assign temp      = {1'b0, half_reg} + {1'b0, rem_reg};

    always_comb
    begin
        interval_next = interval_reg;
        scale_next    = scale_reg;
        leftover_next = leftover_reg;
        op_next       = op_reg;
        rnd_next      = rnd_reg;
        half_next     = half_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        fire_next     = fire_reg;
        if (ctrl.cfg_load)
        begin
            interval_next = ctrl.initial_value;
            scale_next    = 1'b0;
            leftover_next = '0;
        end
        else
        begin
            unique case (ctrl.uop)
                UOP_LATCH:
                begin
                    op_next  = in_item.operation;
                    rnd_next = in_item.random_value;
                end
                UOP_GROW:
                begin
                    if (interval_reg < (ctrl.maximum_value >> 1))
                        interval_next = scale_reg ? {interval_reg[IntervalWidth-2:0], 1'b0}
                                                  : interval_reg;
                    else
                        interval_next = ctrl.maximum_value;
                    scale_next = 1'b1;
                end
                UOP_HALF:
                begin
                    half_next = interval_reg[IntervalWidth-1:1];
                    rem_next  = '0;
                    cnt_next  = '0;
                end
                UOP_DIV:
                begin
                    if (rem_shift >= {1'b0, half_reg})
                        rem_next = rem_sub[IntervalWidth-2:0];
                    else
                        rem_next = rem_shift[IntervalWidth-2:0];
                    rnd_next = {rnd_reg[IntervalWidth-2:0], 1'b0};
                    cnt_next = cnt_reg + 4'd1;
                end
                UOP_TEMP:
                begin
                    fire_next     = {1'b0, temp} + {1'b0, leftover_reg};
                    leftover_next = interval_reg - temp;
                end
                UOP_CLEAR:
                begin
                    interval_next = ctrl.initial_value;
                    leftover_next = '0;
                    fire_next     = '0;
                end
                UOP_NOP, UOP_EMIT:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INITIAL_RESET;
            scale_reg    <= 1'b0;
            leftover_reg <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            interval_reg <= interval_next;
            scale_reg    <= scale_next;
            leftover_reg <= leftover_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rnd_reg  <= rnd_next;
        half_reg <= half_next;
        rem_reg  <= rem_next;
        fire_reg <= fire_next;
    end

    assign stat.op_reset  = (op_reg == OP_RESET);
    assign stat.half_zero = (interval_reg[IntervalWidth-1:1] == '0);
    assign stat.div_more  = (cnt_reg != DIV_LAST);
    assign fire_time      = fire_reg;
    assign interval       = interval_reg;

    // partial remainder stays below the divisor throughout the division
    a_rem_below_half: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.uop == UOP_DIV && !ctrl.cfg_load) |-> (rem_reg < half_reg))
        else $error("remainder not below half interval");

    // new leftover plus temp gives back the interval
    a_leftover_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.uop == UOP_TEMP && !ctrl.cfg_load)
        |=> (leftover_reg + $past(temp) == interval_reg))
        else $error("leftover does not complete the interval");

endmodule

// ===== rtl/trickle_interval_timer_top.sv =====
// trickle interval timer top level: apb registers, microcoded sequencer, output register
// depends on tit_pkg and tit_datapath
//
// usage
// - input channel in_valid/in_ready/in_item carries one transaction per trickle
//   event: operation run grows the interval and draws a fire time from
//   random_value; operation reset reloads the initial interval
// - output channel out_valid/out_ready/out_item returns exactly one transaction
//   per input: fire_time, current_interval and at_initial
// - a run is accepted at the latch step and reaches out_valid through grow, halve,
//   16 remainder steps, temp and emit, skipping the remainder steps when half the
//   interval is zero; a reset item takes clear and emit
// - rate is set by the restoring divider, one quotient bit per cycle; the next item
//   is taken only in the cycle after the last one's emit step
// - when the receiver stalls, the result waits in the output register; the
//   sequencer still accepts and works the next item and holds it at the emit
//   step until the register is free
// - apb writes to initial_interval (0x0) or maximum_interval (0x4) reload the
//   interval and clear the leftover and the scaling factor; write only when idle
// - after rst_n the registers are 16 and 1024, interval 16, no result pending
module trickle_interval_timer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  tit_pkg::in_item_t                  in_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output tit_pkg::out_item_t                 out_item,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tit_pkg::AddrWidth-1:0]      paddr,
    input  logic [tit_pkg::DataWidth-1:0]      pwdata,
    output logic [tit_pkg::DataWidth-1:0]      prdata,
    output logic                               pready
);
    import tit_pkg::*;

    // configuration registers
    logic [IntervalWidth-1:0] initial_reg, initial_next;
    logic [IntervalWidth-1:0] maximum_reg, maximum_next;
    logic                     cfg_write;
    logic                     cfg_index;

    // sequencer
    logic [PcWidth-1:0] pc_reg, pc_next;
    ucode_t             uword;
    logic               step_go;
    logic               take_jump;

    // output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;
    logic      out_free;

    dp_ctrl_t                 ctrl;
    dp_stat_t                 stat;
    logic [FireWidth-1:0]     dp_fire;
    logic [IntervalWidth-1:0] dp_interval;

    // apb: word address, index in bit 2, zero wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[2];

    always_comb
    begin
        initial_next = initial_reg;
        maximum_next = maximum_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INITIAL: initial_next = pwdata[IntervalWidth-1:0];
                REG_MAXIMUM: maximum_next = pwdata[IntervalWidth-1:0];
                default:     initial_next = initial_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_INITIAL: prdata = {{(DataWidth-IntervalWidth){1'b0}}, initial_reg};
            REG_MAXIMUM: prdata = {{(DataWidth-IntervalWidth){1'b0}}, maximum_reg};
            default:     prdata = '0;
        endcase
    end

    // output slot free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    // fetch the control word and decide whether this step completes
    assign uword = ucode_rom(pc_reg);

    always_comb
    begin
        unique case (uword.hold)
            HOLD_IN:   step_go = in_valid;
            HOLD_OUT:  step_go = out_free;
            HOLD_NONE: step_go = 1'b1;
            default:   step_go = 1'b1;
        endcase
    end

    assign in_ready = (uword.hold == HOLD_IN);

    // conditional jumps; status of the latch step comes from the incoming item
    always_comb
    begin
        unique case (uword.jump)
            JMP_ALWAYS:       take_jump = 1'b1;
            JMP_IF_RESET:     take_jump = (in_item.operation == OP_RESET);
            JMP_IF_HALF_ZERO: take_jump = stat.half_zero;
            JMP_IF_DIV_MORE:  take_jump = stat.div_more;
            JMP_NEXT:         take_jump = 1'b0;
            default:          take_jump = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (step_go)
            pc_next = take_jump ? uword.target : pc_reg + 3'd1;
    end

    // datapath control: micro-op only fires when the step completes
    always_comb
    begin
        ctrl.uop           = step_go ? uword.uop : UOP_NOP;
        ctrl.cfg_load      = cfg_write;
        ctrl.initial_value = initial_next;
        ctrl.maximum_value = maximum_reg;
    end

    tit_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_item   (in_item),
        .stat      (stat),
        .fire_time (dp_fire),
        .interval  (dp_interval)
    );

    // emit step loads the result register; a taken transaction drains it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (step_go && uword.uop == UOP_EMIT)
        begin
            out_valid_next                 = 1'b1;
            out_item_next.fire_time        = dp_fire;
            out_item_next.current_interval = dp_interval;
            out_item_next.at_initial       = (dp_interval == initial_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_reg   <= INITIAL_RESET;
            maximum_reg   <= MAXIMUM_RESET;
            pc_reg        <= PC_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            initial_reg   <= initial_next;
            maximum_reg   <= maximum_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // an accepted run item heads for the grow step, a reset item for the clear step
    a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready)
        |=> (pc_reg == PC_GROW || pc_reg == PC_CLEAR))
        else $error("bad dispatch after input transaction");

    // a completed emit step always leaves a pending result
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && uword.uop == UOP_EMIT) |=> out_valid_reg)
        else $error("emit step did not load result");

    // a reset item reports zero fire time
    a_clear_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_CLEAR && !cfg_write) |=> (dp_fire == '0))
        else $error("reset item left nonzero fire time");

endmodule

// ===== bench/tb_trickle_interval_timer_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the trickle interval timer: directed table, then random phases
// depends on tit_pkg and trickle_interval_timer_top; a built-in predictor or a typed row checks every result

module tb_trickle_interval_timer_top;

    import tit_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned LONG_HOLD    = 300;   // receiver hold-off, in cycles
    localparam int unsigned IDLE_SETTLE  = 8;     // margin after the last result before a write
    localparam int unsigned DRAIN_CYCLES = 40;    // run latency plus margin at the end
    localparam int unsigned REPORT_MAX   = 10;
    localparam int unsigned PHASES       = 4;
    localparam int unsigned BATCHES      = 4;
    localparam int unsigned BATCH_ITEMS  = 25;

    // ------------------------------------------------------------------
    // clock, reset and dut signals
    // ------------------------------------------------------------------
    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [AddrWidth-1:0] paddr;
    logic [DataWidth-1:0] pwdata;
    logic [DataWidth-1:0] prdata;
    logic                 pready;

    always #4 clk = ~clk;

    trickle_interval_timer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // ------------------------------------------------------------------
    // shadow copy of the timer: registers and running state
    // ------------------------------------------------------------------
    logic [15:0] shadow_initial;
    logic [15:0] shadow_maximum;
    logic [15:0] shadow_interval;
    logic        shadow_doubling;   // scaling factor, 0 until the first run
    logic [15:0] shadow_leftover;

    // results still owed by the dut, oldest first
    out_item_t   awaited_results [$];

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned ready_stall_pct = 0;

    // long receiver hold-off: main bumps the request count, the receiver serves it
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;

    // opening the timer: reload interval, clear scaling and leftover
    function automatic void open_timer();
        shadow_interval = shadow_initial;
        shadow_doubling = 1'b0;
        shadow_leftover = '0;
    endfunction

    function automatic void write_interval_reg(logic reg_sel, logic [15:0] value);
        if (reg_sel == REG_INITIAL)
            shadow_initial = value;
        else
            shadow_maximum = value;
        open_timer();
    endfunction

    // one trickle event: grow the interval, draw temp in its second half, add the leftover, or reload on a reset
    function automatic out_item_t step_trickle(in_item_t item);
        out_item_t   res;
        logic [15:0] half;
        logic [16:0] temp;
        logic [16:0] fire;
        fire = '0;
        if (item.operation == OP_RUN) begin
            if (shadow_interval < (shadow_maximum >> 1))
                shadow_interval = shadow_interval << shadow_doubling;
            else
                shadow_interval = shadow_maximum;
            shadow_doubling = 1'b1;
            half = shadow_interval >> 1;
            temp = {1'b0, half};
            // zero half interval means no random offset
            if (half != 16'd0)
                temp = half + (item.random_value % half);
            fire = temp + shadow_leftover;
            shadow_leftover = shadow_interval - temp[15:0];
        end
        else begin
            shadow_interval = shadow_initial;
            shadow_leftover = '0;
        end
        res.fire_time        = fire;
        res.current_interval = shadow_interval;
        res.at_initial       = (shadow_interval == shadow_initial);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // directed stimulus table
    // typed rows carry an expectation read straight off the spec, the others use the predictor
    // ------------------------------------------------------------------
    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        reg_sel;
        logic [15:0] value;
        logic        operation;
        logic [15:0] random_value;
        bit          typed;
        logic [16:0] exp_fire;
        logic [15:0] exp_interval;
        logic        exp_at_initial;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 26;

    //  kind      reg          value     op        random    typed fire      interval  at_init
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RESET, 16'h0000, 1'b1, 17'd0,     16'd16,    1'b1},
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RUN,   16'h0000, 1'b1, 17'd8,     16'd16,    1'b1},
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RUN,   16'h0000, 1'b1, 17'd24,    16'd32,    1'b0},
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RUN,   16'hFFFF, 1'b0, 17'd0,     16'd0,     1'b0},
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RUN,   16'h5555, 1'b0, 17'd0,     16'd0,     1'b0},
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RUN,   16'hAAAA, 1'b0, 17'd0,     16'd0,     1'b0},
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RESET, 16'hFFFF, 1'b1, 17'd0,     16'd16,    1'b1},
        '{ROW_CFG,  REG_MAXIMUM, 16'hFFFF, OP_RUN,   16'h0000, 1'b0, 17'd0,     16'd0,     1'b0},
        '{ROW_CFG,  REG_INITIAL, 16'hFFFF, OP_RUN,   16'h0000, 1'b0, 17'd0,     16'd0,     1'b0},
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RUN,   16'hFFFF, 1'b1, 17'd32768, 16'd65535, 1'b1},
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RUN,   16'h7FFE, 1'b0, 17'd0,     16'd0,     1'b0},
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RUN,   16'hFFFF, 1'b0, 17'd0,     16'd0,     1'b0},
        '{ROW_CFG,  REG_INITIAL, 16'h0001, OP_RUN,   16'h0000, 1'b0, 17'd0,     16'd0,     1'b0},
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RUN,   16'hFFFF, 1'b1, 17'd0,     16'd1,     1'b1},
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RUN,   16'h1234, 1'b0, 17'd0,     16'd0,     1'b0},
        '{ROW_CFG,  REG_INITIAL, 16'h0000, OP_RUN,   16'h0000, 1'b0, 17'd0,     16'd0,     1'b0},
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RUN,   16'hFFFF, 1'b1, 17'd0,     16'd0,     1'b1},
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RESET, 16'h0000, 1'b1, 17'd0,     16'd0,     1'b1},
        '{ROW_CFG,  REG_INITIAL, 16'd100,  OP_RUN,   16'h0000, 1'b0, 17'd0,     16'd0,     1'b0},
        '{ROW_CFG,  REG_MAXIMUM, 16'h0000, OP_RUN,   16'h0000, 1'b0, 17'd0,     16'd0,     1'b0},
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RUN,   16'h0003, 1'b1, 17'd0,     16'd0,     1'b0},
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RESET, 16'h0000, 1'b1, 17'd0,     16'd100,   1'b1},
        '{ROW_CFG,  REG_MAXIMUM, 16'h0001, OP_RUN,   16'h0000, 1'b0, 17'd0,     16'd0,     1'b0},
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RUN,   16'h0007, 1'b1, 17'd0,     16'd1,     1'b0},
        '{ROW_ITEM, REG_INITIAL, 16'h0000, OP_RUN,   16'h0007, 1'b1, 17'd1,     16'd1,     1'b0},
        '{ROW_CFG,  REG_MAXIMUM, 16'd1024, OP_RUN,   16'h0000, 1'b0, 17'd0,     16'd0,     1'b0}
    };

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offer one transaction after a random gap; expectation is queued at acceptance
    task automatic send_item(in_item_t item, bit typed, out_item_t typed_exp);
        out_item_t predicted;
        while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = step_trickle(item);
        awaited_results.push_back(typed ? typed_exp : predicted);
    endtask

    // quiet input, every result back, then let the sequencer settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // apb write: setup cycle, access cycle, then bus idle
    task automatic write_register(logic reg_sel, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {16'($urandom), value};   // upper bits are don't-care
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        write_interval_reg(reg_sel, value);
        @(posedge clk);
    endtask

    // interval register value: extremes now and then, otherwise a working range
    function automatic logic [15:0] pick_interval(int unsigned lo, int unsigned hi);
        case ($urandom_range(0, 9))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // receiver side: random stalls, plus the long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            out_ready   <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // result checker: each output transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && out_valid && out_ready) begin
            if (awaited_results.size() == 0) begin
                if (fail_count < REPORT_MAX)
                    $display("[%0t] unexpected result: fire %0d interval %0d at_initial %0d",
                             $realtime, out_item.fire_time, out_item.current_interval,
                             out_item.at_initial);
                fail_count++;
            end
            else begin
                want = awaited_results.pop_front();
                if (out_item.fire_time !== want.fire_time
                        || out_item.current_interval !== want.current_interval
                        || out_item.at_initial !== want.at_initial) begin
                    if (fail_count < REPORT_MAX) begin
                        $write("[%0t] mismatch (expected/actual): ", $realtime);
                        $display("fire %0d/%0d interval %0d/%0d at_initial %0d/%0d",
                                 want.fire_time, out_item.fire_time,
                                 want.current_interval, out_item.current_interval,
                                 want.at_initial, out_item.at_initial);
                    end
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        in_item_t  item;
        out_item_t typed_exp;
        int unsigned idle_pcts  [PHASES];
        int unsigned stall_pcts [PHASES];

        idle_pcts  = '{0, 56, 0, 21};
        stall_pcts = '{0, 0, 56, 21};

        rst_n   = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        // register reset values, then open
        shadow_initial = INITIAL_RESET;
        shadow_maximum = MAXIMUM_RESET;
        open_timer();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_register(directed_rows[i].reg_sel, directed_rows[i].value);
            end
            else begin
                item.operation              = directed_rows[i].operation;
                item.random_value           = directed_rows[i].random_value;
                typed_exp.fire_time         = directed_rows[i].exp_fire;
                typed_exp.current_interval  = directed_rows[i].exp_interval;
                typed_exp.at_initial        = directed_rows[i].exp_at_initial;
                send_item(item, directed_rows[i].typed, typed_exp);
            end
        end

        // random phases, each with its own idling mix and several register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            sender_idle_pct = idle_pcts[ph];
            ready_stall_pct <= stall_pcts[ph];
            for (int b = 0; b < BATCHES; b++) begin
                wait_idle();
                case ($urandom_range(0, 2))
                    0: write_register(REG_INITIAL, pick_interval(1, 64));
                    1: write_register(REG_MAXIMUM, pick_interval(64, 8192));
                    default:
                    begin
                        write_register(REG_INITIAL, pick_interval(1, 64));
                        write_register(REG_MAXIMUM, pick_interval(64, 8192));
                    end
                endcase
                for (int n = 0; n < BATCH_ITEMS; n++) begin
                    // long receiver hold-off while the sender keeps offering
                    if (ph == 0 && b == 1 && n == 5)
                        hold_requests <= hold_requests + 1;
                    // sender pause until everything outstanding is back
                    if (ph == 1 && b == 2 && n == 12) begin
                        in_valid <= 1'b0;
                        while (awaited_results.size() != 0)
                            @(posedge clk);
                    end
                    item.operation    = ($urandom_range(0, 99) < 12) ? OP_RESET : OP_RUN;
                    item.random_value = 16'($urandom);
                    send_item(item, 1'b0, '0);
                end
            end
        end

        // drain
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
